### rtl/hhp_pkg.sv
// shared types and constants for the http header block parser
`timescale 1ns / 1ps
`default_nettype none

package hhp_pkg;

   localparam int unsigned MaxOffsetWidth = 12;
   localparam int unsigned OffsetWidth    = 13;

   localparam logic [MaxOffsetWidth-1:0] MaxOffsetReset = 12'd255;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [2:0] ROLE_SKIP  = 3'd0;
   localparam logic [2:0] ROLE_KEY   = 3'd1;
   localparam logic [2:0] ROLE_SEP   = 3'd2;
   localparam logic [2:0] ROLE_VALUE = 3'd3;
   localparam logic [2:0] ROLE_TERM  = 3'd4;

   localparam logic [1:0] STAT_BUSY  = 2'd0;
   localparam logic [1:0] STAT_LINE  = 2'd1;
   localparam logic [1:0] STAT_BLOCK = 2'd2;
   localparam logic [1:0] STAT_ERROR = 2'd3;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [3:0] {
      ST_START  = 4'd0,
      ST_KEY    = 4'd1,
      ST_COLON  = 4'd2,
      ST_SPACE  = 4'd3,
      ST_VALUE  = 4'd4,
      ST_CR     = 4'd5,
      ST_LF     = 4'd6,
      ST_END_CR = 4'd7,
      ST_DONE   = 4'd8,
      ST_ERR    = 4'd9
   } parse_state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
   } req_word_type;

   typedef struct packed {
      logic [7:0] byte_echo;
      logic [2:0] byte_role;
      logic [1:0] status;
   } rsp_word_type;

   typedef struct packed {
      parse_state_type        state_next;
      logic [OffsetWidth-1:0] offset_next;
      rsp_word_type           word;
   } step_type;

endpackage

`default_nettype wire

### rtl/hhp_csr.sv
// configuration register holding the value length limit
`timescale 1ns / 1ps
`default_nettype none

module hhp_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hhp_pkg::MaxOffsetWidth-1:0] csr_data,
   output logic [hhp_pkg::MaxOffsetWidth-1:0]      max_value_offset
);
   import hhp_pkg::*;

   logic [MaxOffsetWidth-1:0] max_offset_ff;
   logic [MaxOffsetWidth-1:0] max_offset_in;

   assign csr_ready = 1'b1;

   always_comb begin
      max_offset_in = max_offset_ff;
      if (csr_valid) begin
         max_offset_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_offset_ff <= MaxOffsetReset;
      end else begin
         max_offset_ff <= max_offset_in;
      end
   end

   assign max_value_offset = max_offset_ff;

endmodule

`default_nettype wire

### rtl/hhp_step.sv
// header state machine transition and byte tagging for one word
`timescale 1ns / 1ps
`default_nettype none

module hhp_step (
   input  wire hhp_pkg::parse_state_type               state,
   input  wire logic [hhp_pkg::OffsetWidth-1:0]        value_offset,
   input  wire logic [hhp_pkg::MaxOffsetWidth-1:0]     max_value_offset,
   input  wire hhp_pkg::req_word_type                  req_word,
   output hhp_pkg::step_type                           step
);
   import hhp_pkg::*;

   logic [7:0]             b;
   logic                   is_cr;
   logic                   is_lf;
   logic                   restart;
   logic [OffsetWidth-1:0] max_ext;
   logic [OffsetWidth-1:0] offset_inc;
   logic                   err;
   parse_state_type        state_next;
   logic [OffsetWidth-1:0] offset_next;
   logic [2:0]             role;
   logic [1:0]             stat;

   assign b       = req_word.byte_value;
   assign is_cr   = (b == CH_CR);
   assign is_lf   = (b == CH_LF);
   assign restart = (req_word.kind == KIND_RESTART);
   assign max_ext = {1'b0, max_value_offset};

   // offset advances only while within the limit
   assign offset_inc = (value_offset <= max_ext) ? value_offset + 1'b1 : value_offset;

   // syntax and length errors
   always_comb begin
      err = 1'b0;
      case (state)
         ST_KEY:    err = (b != CH_COLON) && (is_cr || is_lf);
         ST_COLON:  err = (b != CH_SPACE);
         ST_VALUE:  err = !is_cr && (offset_inc > max_ext);
         ST_CR:     err = !is_lf;
         ST_END_CR: err = !is_lf;
         default:   err = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_next  = state;
      offset_next = value_offset;
      case (state)
         ST_START: begin
            if (!is_cr && !is_lf) begin
               state_next = ST_KEY;
            end
         end
         ST_KEY: begin
            if (b == CH_COLON) begin
               state_next = ST_COLON;
            end
         end
         ST_COLON: begin
            state_next = ST_SPACE;
         end
         ST_SPACE: begin
            state_next  = ST_VALUE;
            offset_next = '0;
         end
         ST_VALUE: begin
            if (is_cr) begin
               state_next = ST_CR;
            end else begin
               offset_next = offset_inc;
            end
         end
         ST_CR: begin
            state_next = ST_LF;
         end
         ST_LF: begin
            state_next = is_cr ? ST_END_CR : ST_KEY;
         end
         ST_END_CR: begin
            state_next = ST_DONE;
         end
         ST_DONE: begin
            state_next = ST_DONE;
         end
         default: begin
            state_next = ST_ERR;
         end
      endcase
      if (err) begin
         state_next = ST_ERR;
      end
      if (restart) begin
         state_next  = ST_START;
         offset_next = '0;
      end
   end

   // role and status of the word
   always_comb begin
      role = ROLE_SKIP;
      stat = STAT_BUSY;
      case (state)
         ST_START:  role = (!is_cr && !is_lf) ? ROLE_KEY : ROLE_SKIP;
         ST_KEY:    role = (b == CH_COLON) ? ROLE_SEP : ROLE_KEY;
         ST_COLON:  role = ROLE_SEP;
         ST_SPACE:  role = ROLE_VALUE;
         ST_VALUE:  role = is_cr ? ROLE_TERM : ROLE_VALUE;
         ST_CR: begin
            role = ROLE_TERM;
            stat = STAT_LINE;
         end
         ST_LF:     role = is_cr ? ROLE_TERM : ROLE_KEY;
         ST_END_CR: begin
            role = ROLE_TERM;
            stat = STAT_BLOCK;
         end
         ST_DONE:   stat = STAT_BLOCK;
         default:   stat = STAT_ERROR;
      endcase
      if (err) begin
         role = ROLE_SKIP;
         stat = STAT_ERROR;
      end
   end

   always_comb begin
      step.state_next  = state_next;
      step.offset_next = offset_next;
      if (restart) begin
         step.word = '0;
      end else begin
         step.word.byte_echo = b;
         step.word.byte_role = role;
         step.word.status    = stat;
      end
   end

endmodule

`default_nettype wire

### rtl/http_header_block_parser_unit.sv
// top level of the http header block parser
// latency: a word accepted at one edge shows its result word from the next cycle
// throughput: one byte per cycle while no result word is stalled, set by the single state register update
// a waiting result word blocks the input only when rsp_ready is low
// reset: synchronous, starts in the start state with the length limit at 255
`timescale 1ns / 1ps
`default_nettype none

module http_header_block_parser_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire hhp_pkg::req_word_type              req_word,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output hhp_pkg::rsp_word_type                   rsp_word,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hhp_pkg::MaxOffsetWidth-1:0] csr_data
);
   import hhp_pkg::*;

   logic [MaxOffsetWidth-1:0] max_value_offset;
   parse_state_type           state_ff;
   parse_state_type           state_in;
   logic [OffsetWidth-1:0]    offset_ff;
   logic [OffsetWidth-1:0]    offset_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_word_type              rsp_word_ff;
   rsp_word_type              rsp_word_in;
   step_type                  step;
   logic                      req_accept;

   hhp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .max_value_offset (max_value_offset)
   );

   hhp_step u_step (
      .state            (state_ff),
      .value_offset     (offset_ff),
      .max_value_offset (max_value_offset),
      .req_word         (req_word),
      .step             (step)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         state_in     = step.state_next;
         offset_in    = step.offset_next;
         rsp_word_in  = step.word;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

### rtl/hhp_checker.sv
// port level checks for the http header block parser and their bind
`timescale 1ns / 1ps
`default_nettype none

module hhp_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire hhp_pkg::req_word_type req_word,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire hhp_pkg::rsp_word_type rsp_word
);
   import hhp_pkg::*;

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // no new word taken while a result word is stuck
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted over a stalled result");

   // restart gives an all zero result word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_word.kind == KIND_RESTART)
      |=> rsp_valid && (rsp_word == '0))
      else $error("restart result word not zero");

   // data byte is echoed in the next result word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_word.kind == KIND_DATA)
      |=> rsp_valid && (rsp_word.byte_echo == $past(req_word.byte_value)))
      else $error("byte echo mismatch");

endmodule

bind http_header_block_parser_unit hhp_checker u_hhp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

`default_nettype wire
